// ===== sv/wpv_pkg.sv =====
// ----------------------------------------------------------------------------
// wpv_pkg
// Shared widths, codes, control word layout and the sequencer program for the
// weighted pointer velocity estimator.
// ----------------------------------------------------------------------------
package wpv_pkg;

    localparam int DEPTH_DEF  = 4;

    localparam int OPC_W      = 2;
    localparam int POS_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int VEL_W      = 26;

    // Differences of two samples.
    localparam int DX_W       = POS_W + 1;
    localparam int DT_W       = STAMP_W + 1;

    // Pair weight 64*i*i for i up to 14 fits in 14 bits.
    localparam int W_W        = 14;
    localparam int WEIGHT_SH  = 6;
    localparam int FRAC_SH    = 8;
    localparam int MUL_W      = W_W + 1 + DX_W;

    // Running totals: fifteen terms of at most 39 bits each.
    localparam int TOT_W      = 44;
    localparam int SC_W       = 17;

    localparam logic signed [TOT_W-1:0] VEL_MAX = TOT_W'(64'sd16777216);
    localparam logic signed [TOT_W-1:0] VEL_MIN = -VEL_MAX;

    typedef enum logic [OPC_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_STORE = 2'd1,
        CMD_EST   = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_READ,
        OP_DIFF,
        OP_MULX,
        OP_MULY,
        OP_DIVP,
        OP_ACCX,
        OP_ACCY,
        OP_NEXT,
        OP_FDIVX,
        OP_FDIVY,
        OP_SETX,
        OP_SETY,
        OP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_EST,
        C_DT_ZERO,
        C_DIV_BUSY,
        C_MORE,
        C_SCALE_ZERO,
        C_OUT_BLOCKED
    } cond_t;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE  = 5'd0;
    localparam step_t S_INIT  = 5'd1;
    localparam step_t S_READ  = 5'd2;
    localparam step_t S_DIFF  = 5'd3;
    localparam step_t S_MULX  = 5'd4;
    localparam step_t S_DIVX  = 5'd5;
    localparam step_t S_ACCX  = 5'd6;
    localparam step_t S_MULY  = 5'd7;
    localparam step_t S_DIVY  = 5'd8;
    localparam step_t S_ACCY  = 5'd9;
    localparam step_t S_NEXT  = 5'd10;
    localparam step_t S_FIN   = 5'd11;
    localparam step_t S_FDIVX = 5'd12;
    localparam step_t S_SETX  = 5'd13;
    localparam step_t S_FDIVY = 5'd14;
    localparam step_t S_SETY  = 5'd15;
    localparam step_t S_OUT   = 5'd16;
    localparam step_t S_RET   = 5'd17;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } uword_t;

    typedef struct packed {
        logic est_go;
        logic dt_zero;
        logic div_busy;
        logic more_pairs;
        logic scale_zero;
        logic out_blocked;
    } status_t;

    // Program store. A step jumps to its target when its condition holds and
    // falls through to the next step otherwise.
    function automatic uword_t ucode(step_t s);
        uword_t w;
        begin
            unique case (s)
                S_IDLE:  w = '{OP_NOP,   C_NO_EST,      S_IDLE};
                S_INIT:  w = '{OP_INIT,  C_NEVER,       S_IDLE};
                S_READ:  w = '{OP_READ,  C_NEVER,       S_IDLE};
                S_DIFF:  w = '{OP_DIFF,  C_DT_ZERO,     S_NEXT};
                S_MULX:  w = '{OP_MULX,  C_NEVER,       S_IDLE};
                S_DIVX:  w = '{OP_DIVP,  C_NEVER,       S_IDLE};
                S_ACCX:  w = '{OP_ACCX,  C_DIV_BUSY,    S_ACCX};
                S_MULY:  w = '{OP_MULY,  C_NEVER,       S_IDLE};
                S_DIVY:  w = '{OP_DIVP,  C_NEVER,       S_IDLE};
                S_ACCY:  w = '{OP_ACCY,  C_DIV_BUSY,    S_ACCY};
                S_NEXT:  w = '{OP_NEXT,  C_MORE,        S_READ};
                S_FIN:   w = '{OP_NOP,   C_SCALE_ZERO,  S_OUT};
                S_FDIVX: w = '{OP_FDIVX, C_NEVER,       S_IDLE};
                S_SETX:  w = '{OP_SETX,  C_DIV_BUSY,    S_SETX};
                S_FDIVY: w = '{OP_FDIVY, C_NEVER,       S_IDLE};
                S_SETY:  w = '{OP_SETY,  C_DIV_BUSY,    S_SETY};
                S_OUT:   w = '{OP_OUT,   C_OUT_BLOCKED, S_OUT};
                S_RET:   w = '{OP_NOP,   C_ALWAYS,      S_IDLE};
                default: w = '{OP_NOP,   C_ALWAYS,      S_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== sv/wpv_ring.sv =====
// ----------------------------------------------------------------------------
// wpv_ring
// Sample ring memory with one write port and two registered read ports.
// A per-entry valid bit makes cleared entries read as zero.
// ----------------------------------------------------------------------------
module wpv_ring
    import wpv_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clr,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [POS_W-1:0]     wr_x,
    input  logic [POS_W-1:0]     wr_y,
    input  logic [STAMP_W-1:0]   wr_t,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr_a,
    input  logic [IDX_W-1:0]     rd_addr_b,
    output logic [POS_W-1:0]     rd_x_a,
    output logic [POS_W-1:0]     rd_y_a,
    output logic [STAMP_W-1:0]   rd_t_a,
    output logic [POS_W-1:0]     rd_x_b,
    output logic [POS_W-1:0]     rd_y_b,
    output logic [STAMP_W-1:0]   rd_t_b
);

    logic [POS_W-1:0]   mem_x [DEPTH];
    logic [POS_W-1:0]   mem_y [DEPTH];
    logic [STAMP_W-1:0] mem_t [DEPTH];
    logic [DEPTH-1:0]   valid_reg;

    logic [POS_W-1:0]   rd_x_a_reg, rd_y_a_reg, rd_x_b_reg, rd_y_b_reg;
    logic [STAMP_W-1:0] rd_t_a_reg, rd_t_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
            mem_t[wr_addr] <= wr_t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_x_a_reg <= valid_reg[rd_addr_a] ? mem_x[rd_addr_a] : '0;
            rd_y_a_reg <= valid_reg[rd_addr_a] ? mem_y[rd_addr_a] : '0;
            rd_t_a_reg <= valid_reg[rd_addr_a] ? mem_t[rd_addr_a] : '0;
            rd_x_b_reg <= valid_reg[rd_addr_b] ? mem_x[rd_addr_b] : '0;
            rd_y_b_reg <= valid_reg[rd_addr_b] ? mem_y[rd_addr_b] : '0;
            rd_t_b_reg <= valid_reg[rd_addr_b] ? mem_t[rd_addr_b] : '0;
        end
    end

    assign rd_x_a = rd_x_a_reg;
    assign rd_y_a = rd_y_a_reg;
    assign rd_t_a = rd_t_a_reg;
    assign rd_x_b = rd_x_b_reg;
    assign rd_y_b = rd_y_b_reg;
    assign rd_t_b = rd_t_b_reg;

endmodule

// ===== sv/wpv_div.sv =====
// ----------------------------------------------------------------------------
// wpv_div
// Bit-serial signed divider, one quotient bit per cycle, truncating toward
// zero. Busy rises the cycle after start and falls with the quotient ready.
// ----------------------------------------------------------------------------
module wpv_div
    import wpv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [TOT_W-1:0] dividend,
    input  logic signed [DT_W-1:0]  divisor,
    output logic                    busy,
    output logic signed [TOT_W-1:0] quotient
);

    localparam int CNT_W = $clog2(TOT_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [TOT_W-1:0] quo_reg;
    logic [DT_W-1:0]  rem_reg;
    logic [DT_W-1:0]  dvs_reg;
    logic             neg_reg;

    logic [DT_W:0]    trial;
    logic [DT_W:0]    diff;

    assign trial = {rem_reg, quo_reg[TOT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(TOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[TOT_W-1] ? (~dividend + TOT_W'(1)) : dividend;
            dvs_reg <= divisor[DT_W-1] ? (~divisor + DT_W'(1)) : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[TOT_W-1] ^ divisor[DT_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DT_W])
            begin
                rem_reg <= diff[DT_W-1:0];
                quo_reg <= {quo_reg[TOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DT_W-1:0];
                quo_reg <= {quo_reg[TOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== sv/wpv_seq.sv =====
// ----------------------------------------------------------------------------
// wpv_seq
// Step counter and program store. Each step issues one control word; a
// condition from the datapath selects between the jump target and the next
// step.
// ----------------------------------------------------------------------------
module wpv_seq
    import wpv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t st,
    output uword_t  uw,
    output logic    idle
);

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   take;

    assign word = ucode(step_reg);

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:       take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NO_EST:      take = !st.est_go;
            C_DT_ZERO:     take = st.dt_zero;
            C_DIV_BUSY:    take = st.div_busy;
            C_MORE:        take = st.more_pairs;
            C_SCALE_ZERO:  take = st.scale_zero;
            C_OUT_BLOCKED: take = st.out_blocked;
            default:       take = 1'b1;
        endcase
        step_next = take ? word.target : step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign uw   = word;
    assign idle = (step_reg == S_IDLE);

endmodule

// ===== sv/weighted_pointer_velocity.sv =====
// ----------------------------------------------------------------------------
// weighted_pointer_velocity
// Pointer velocity estimator over a ring of timed samples, run by a small
// microprogram over a shared multiplier and divider.
// ----------------------------------------------------------------------------
// Clear and store items are taken while the sequencer is idle. An estimate
// walks the ring pairs under the microprogram; each pair with a nonzero time
// step runs the bit-serial divider twice, and the final normalization runs it
// twice more when the weight sum is nonzero. A finished estimate sits in the
// output register, and the next item can be taken while it waits.
// ----------------------------------------------------------------------------
module weighted_pointer_velocity
    import wpv_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OPC_W-1:0]          opcode,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic [STAMP_W-1:0]        stamp,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VEL_W-1:0]   vel_x,
    output logic signed [VEL_W-1:0]   vel_y
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int IW1   = IDX_W + 1;
    localparam logic [IW1-1:0]   DEPTH_X   = IW1'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] LAST_PAIR = IDX_W'(DEPTH - 2);

    uword_t  uw;
    status_t st;
    logic    idle;
    logic    in_xfer;

    // Ring interface.
    logic [POS_W-1:0]   x_a, y_a, x_b, y_b;
    logic [STAMP_W-1:0] t_a, t_b;
    logic [IDX_W-1:0]   addr_a, addr_b;
    logic [IW1-1:0]     sum_a, sum_b;

    // Datapath registers.
    logic [IDX_W-1:0]        ptr_reg;
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        k_reg;
    logic signed [DX_W-1:0]  dx_reg, dy_reg;
    logic signed [DT_W-1:0]  dt_reg;
    logic [W_W-1:0]          w_reg;
    logic [SC_W-1:0]         scale_reg;
    logic signed [TOT_W-1:0] tot_x_reg, tot_y_reg, prod_reg;
    logic signed [VEL_W-1:0] vel_x_reg, vel_y_reg;

    logic [2*IDX_W-1:0]      k_sq;
    logic signed [DX_W-1:0]  dx_now, dy_now;
    logic signed [DT_W-1:0]  dt_now;
    logic signed [DX_W-1:0]  mul_sel;
    logic signed [MUL_W-1:0] mul_q;
    logic signed [TOT_W-1:0] prod_next;

    logic                    div_start;
    logic signed [TOT_W-1:0] div_num;
    logic signed [DT_W-1:0]  div_den;
    logic                    div_busy;
    logic signed [TOT_W-1:0] div_q;

    logic                    out_blocked;
    logic                    out_load;
    logic signed [VEL_W-1:0] sat_x, sat_y;

    assign in_ready = idle;
    assign in_xfer  = in_valid && in_ready;

    // Pair addresses: newer sample at ptr+2+k, older at ptr+1+k, both mod DEPTH.
    assign sum_a  = {1'b0, ptr_reg} + {1'b0, k_reg} + IW1'(2);
    assign sum_b  = {1'b0, ptr_reg} + {1'b0, k_reg} + IW1'(1);
    assign addr_a = (sum_a >= DEPTH_X) ? IDX_W'(sum_a - DEPTH_X) : IDX_W'(sum_a);
    assign addr_b = (sum_b >= DEPTH_X) ? IDX_W'(sum_b - DEPTH_X) : IDX_W'(sum_b);

    wpv_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (in_xfer && (opcode == CMD_CLEAR)),
        .wr_en     (in_xfer && (opcode == CMD_STORE)),
        .wr_addr   (ptr_reg),
        .wr_x      (pos_x),
        .wr_y      (pos_y),
        .wr_t      (stamp),
        .rd_en     (uw.op == OP_READ),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_x_a    (x_a),
        .rd_y_a    (y_a),
        .rd_t_a    (t_a),
        .rd_x_b    (x_b),
        .rd_y_b    (y_b),
        .rd_t_b    (t_b)
    );

    assign dx_now = $signed({x_a[POS_W-1], x_a}) - $signed({x_b[POS_W-1], x_b});
    assign dy_now = $signed({y_a[POS_W-1], y_a}) - $signed({y_b[POS_W-1], y_b});
    assign dt_now = $signed({1'b0, t_a}) - $signed({1'b0, t_b});
    assign k_sq   = {{IDX_W{1'b0}}, k_reg} * {{IDX_W{1'b0}}, k_reg};

    assign mul_sel   = (uw.op == OP_MULY) ? dy_reg : dx_reg;
    assign mul_q     = MUL_W'($signed({1'b0, w_reg})) * MUL_W'(mul_sel);
    assign prod_next = TOT_W'(mul_q) <<< FRAC_SH;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = prod_reg;
        div_den   = dt_reg;
        unique case (uw.op)
            OP_DIVP:
            begin
                div_start = 1'b1;
            end
            OP_FDIVX:
            begin
                div_start = 1'b1;
                div_num   = tot_x_reg;
                div_den   = $signed(DT_W'(scale_reg));
            end
            OP_FDIVY:
            begin
                div_start = 1'b1;
                div_num   = tot_y_reg;
                div_den   = $signed(DT_W'(scale_reg));
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    wpv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign out_blocked = out_valid_reg && !out_ready;
    assign out_load    = (uw.op == OP_OUT) && !out_blocked;

    always_comb
    begin
        st.est_go      = in_valid && (opcode == CMD_EST);
        st.dt_zero     = (t_a == t_b);
        st.div_busy    = div_busy;
        st.more_pairs  = (k_reg != LAST_PAIR);
        st.scale_zero  = (scale_reg == '0);
        st.out_blocked = out_blocked;
    end

    wpv_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .uw    (uw),
        .idle  (idle)
    );

    // Results clamp to the symmetric output range.
    always_comb
    begin
        if (tot_x_reg > VEL_MAX)
        begin
            sat_x = VEL_W'(VEL_MAX);
        end
        else if (tot_x_reg < VEL_MIN)
        begin
            sat_x = VEL_W'(VEL_MIN);
        end
        else
        begin
            sat_x = VEL_W'(tot_x_reg);
        end
        if (tot_y_reg > VEL_MAX)
        begin
            sat_y = VEL_W'(VEL_MAX);
        end
        else if (tot_y_reg < VEL_MIN)
        begin
            sat_y = VEL_W'(VEL_MIN);
        end
        else
        begin
            sat_y = VEL_W'(tot_y_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer && (opcode == CMD_STORE))
            begin
                ptr_reg <= (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + IDX_W'(1);
            end
            out_valid_reg <= out_blocked || out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (uw.op)
            OP_INIT:
            begin
                k_reg     <= '0;
                scale_reg <= '0;
                tot_x_reg <= '0;
                tot_y_reg <= '0;
            end
            OP_DIFF:
            begin
                dx_reg <= dx_now;
                dy_reg <= dy_now;
                dt_reg <= dt_now;
                w_reg  <= W_W'(k_sq) << WEIGHT_SH;
            end
            OP_MULX:
            begin
                prod_reg  <= prod_next;
                scale_reg <= scale_reg + SC_W'(w_reg);
            end
            OP_MULY:
            begin
                prod_reg <= prod_next;
            end
            OP_ACCX:
            begin
                if (!div_busy)
                begin
                    tot_x_reg <= tot_x_reg + div_q;
                end
            end
            OP_ACCY:
            begin
                if (!div_busy)
                begin
                    tot_y_reg <= tot_y_reg + div_q;
                end
            end
            OP_SETX:
            begin
                if (!div_busy)
                begin
                    tot_x_reg <= div_q;
                end
            end
            OP_SETY:
            begin
                if (!div_busy)
                begin
                    tot_y_reg <= div_q;
                end
            end
            OP_NEXT:
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
            OP_OUT:
            begin
                if (out_load)
                begin
                    vel_x_reg <= sat_x;
                    vel_y_reg <= sat_y;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;

endmodule
